/* rtl/core/skt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// skt_pkg
// Shared sizes, codes and types of the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 16;
    localparam int PAY_W       = 32;
    localparam int ENTRY_W     = KEY_W + PAY_W;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_LIST   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_FOUND     = 3'd5,
        ST_LISTED    = 3'd6,
        ST_EMPTY     = 3'd7
    } status_t;

    typedef struct packed {
        logic [PAY_W-1:0] payload;
        logic [KEY_W-1:0] key;
    } entry_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        logic             last;
    } res_t;

endpackage
`default_nettype wire

/* rtl/core/skt_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// skt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module skt_ram #(
    parameter int DATA_W = 48,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

/* rtl/core/skt_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// skt_engine
// Command sequencer: scans, shifts and lists the entries held in the RAM.
// ----------------------------------------------------------------------------
module skt_engine (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire skt_pkg::req_t              in_req,
    input  wire logic                       out_free,
    output logic                            res_push,
    output skt_pkg::res_t                   res_data,
    output logic                            ram_wr_en,
    output logic [skt_pkg::IDX_W-1:0]       ram_wr_addr,
    output skt_pkg::entry_t                 ram_wr_data,
    output logic [skt_pkg::IDX_W-1:0]       ram_rd_addr,
    input  wire skt_pkg::entry_t            ram_rd_data
);
    import skt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_SHIFT_UP, S_INS_WR, S_SHIFT_DN, S_LIST, S_RESP
    } state_t;

    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_DEPTH);

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [PAY_W-1:0] pay_reg, pay_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic             hit_reg, hit_next;
    logic [PAY_W-1:0] fpay_reg, fpay_next;
    res_t             resp_reg, resp_next;

    logic [CNT_W-1:0] idx_inc, idx_dec;

    assign idx_inc  = idx_reg + ONE;
    assign idx_dec  = idx_reg - ONE;
    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        pay_next    = pay_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        hit_next    = hit_reg;
        fpay_next   = fpay_reg;
        resp_next   = resp_reg;
        ram_rd_addr = '0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = '0;
        res_push    = 1'b0;
        res_data    = resp_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd_next = in_req.cmd;
                    key_next = in_req.key;
                    pay_next = in_req.payload;
                    idx_next = '0;
                    if (count_reg == '0) begin
                        pos_next = '0;
                        hit_next = 1'b0;
                        if (in_req.cmd == CMD_LIST) begin
                            resp_next  = '{status: ST_EMPTY, key: '0, payload: '0, last: 1'b1};
                            state_next = S_RESP;
                        end else begin
                            state_next = S_DECIDE;
                        end
                    end else begin
                        state_next = (in_req.cmd == CMD_LIST) ? S_LIST : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (ram_rd_data.key >= key_reg) begin
                    pos_next   = idx_reg;
                    hit_next   = (ram_rd_data.key == key_reg);
                    fpay_next  = ram_rd_data.payload;
                    state_next = S_DECIDE;
                end else if (idx_inc == count_reg) begin
                    pos_next   = count_reg;
                    hit_next   = 1'b0;
                    state_next = S_DECIDE;
                end else begin
                    idx_next    = idx_inc;
                    ram_rd_addr = idx_inc[IDX_W-1:0];
                end
            end
            S_DECIDE: begin
                resp_next = '{status: ST_NOT_FOUND, key: key_reg, payload: '0, last: 1'b1};
                case (cmd_reg)
                    CMD_INSERT: begin
                        if (hit_reg) begin
                            resp_next.status = ST_DUPLICATE;
                            state_next       = S_RESP;
                        end else if (count_reg == FULL) begin
                            resp_next.status = ST_FULL;
                            state_next       = S_RESP;
                        end else if (pos_reg == count_reg) begin
                            state_next = S_INS_WR;
                        end else begin
                            idx_next    = count_reg - ONE;
                            ram_rd_addr = idx_next[IDX_W-1:0];
                            state_next  = S_SHIFT_UP;
                        end
                    end
                    CMD_LOOKUP: begin
                        if (hit_reg) begin
                            resp_next.status  = ST_FOUND;
                            resp_next.payload = fpay_reg;
                        end
                        state_next = S_RESP;
                    end
                    CMD_REMOVE: begin
                        if (!hit_reg) begin
                            state_next = S_RESP;
                        end else begin
                            resp_next.status  = ST_REMOVED;
                            resp_next.payload = fpay_reg;
                            if (pos_reg + ONE == count_reg) begin
                                count_next = count_reg - ONE;
                                state_next = S_RESP;
                            end else begin
                                idx_next    = pos_reg + ONE;
                                ram_rd_addr = idx_next[IDX_W-1:0];
                                state_next  = S_SHIFT_DN;
                            end
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SHIFT_UP: begin
                // Entry idx moves to idx+1 while idx-1 is being read.
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_inc[IDX_W-1:0];
                ram_wr_data = ram_rd_data;
                if (idx_reg == pos_reg) begin
                    state_next = S_INS_WR;
                end else begin
                    idx_next    = idx_dec;
                    ram_rd_addr = idx_dec[IDX_W-1:0];
                end
            end
            S_INS_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = pos_reg[IDX_W-1:0];
                ram_wr_data = '{payload: pay_reg, key: key_reg};
                count_next  = count_reg + ONE;
                resp_next   = '{status: ST_INSERTED, key: key_reg, payload: '0, last: 1'b1};
                state_next  = S_RESP;
            end
            S_SHIFT_DN: begin
                // Entry idx moves to idx-1 while idx+1 is being read.
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_dec[IDX_W-1:0];
                ram_wr_data = ram_rd_data;
                if (idx_inc == count_reg) begin
                    count_next = count_reg - ONE;
                    state_next = S_RESP;
                end else begin
                    idx_next    = idx_inc;
                    ram_rd_addr = idx_inc[IDX_W-1:0];
                end
            end
            S_LIST: begin
                // The read data always belongs to idx; it is re-read while stalled.
                if (out_free) begin
                    res_push = 1'b1;
                    res_data = '{status: ST_LISTED, key: ram_rd_data.key,
                                 payload: ram_rd_data.payload,
                                 last: (idx_inc == count_reg)};
                    if (idx_inc == count_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next    = idx_inc;
                        ram_rd_addr = idx_inc[IDX_W-1:0];
                    end
                end else begin
                    ram_rd_addr = idx_reg[IDX_W-1:0];
                end
            end
            S_RESP: begin
                if (out_free) begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        cmd_reg  <= cmd_next;
        key_reg  <= key_next;
        pay_reg  <= pay_next;
        idx_reg  <= idx_next;
        pos_reg  <= pos_next;
        hit_reg  <= hit_next;
        fpay_reg <= fpay_next;
        resp_reg <= resp_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL)
        else $error("entry count beyond table depth");

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> out_free)
        else $error("result pushed into an occupied output register");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> (CNT_W'(ram_wr_addr) <= count_reg))
        else $error("table write beyond the occupied region");

endmodule
`default_nettype wire

/* rtl/core/sorted_key_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_table
// Sorted table of unique 16-bit keys with 32-bit payloads: insert, remove,
// lookup and list, all held in one simple dual-port RAM.
// ----------------------------------------------------------------------------
// The block takes one command at a time and holds s_axis_tready low until the
// command has produced its results. With n entries stored and the key at sorted
// position p, the time of a lookup, a refused insert or a remove that misses
// grows with p, and that of an insert, a remove or a list grows with n.
// The single RAM read port sets the pace: the search visits one entry per cycle,
// and each shifted entry costs one read and one
// write, which overlap so that a shift moves one entry per cycle. No clearing
// pass runs after reset; the table starts empty because only entries below the
// entry count are ever read. Results go through an output register, so the
// engine finishes its work while a result waits for m_axis_tready.
module sorted_key_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Command channel.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // entry_key [15:0], entry_payload [47:16]
    input  wire logic [1:0]  s_axis_tuser,   // command [1:0]
    // Result channel.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // result_key [15:0], result_payload [47:16]
    output logic [2:0]       m_axis_tuser,   // status [2:0]
    output logic             m_axis_tlast    // last
);
    import skt_pkg::*;

    req_t             req;
    res_t             res_push_data;
    logic             res_push;
    logic             out_free;
    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    logic [IDX_W-1:0] ram_rd_addr;
    entry_t           ram_wr_data;
    entry_t           ram_rd_data;

    logic             m_valid_reg;
    res_t             m_res_reg;

    assign req.cmd     = cmd_t'(s_axis_tuser);
    assign req.key     = s_axis_tdata[KEY_W-1:0];
    assign req.payload = s_axis_tdata[ENTRY_W-1:KEY_W];

    // The output register can take a new result when it is empty or when
    // its current result is being transferred in this cycle.
    assign out_free = !m_valid_reg || m_axis_tready;

    skt_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_req      (req),
        .out_free    (out_free),
        .res_push    (res_push),
        .res_data    (res_push_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // Keys and payloads share one RAM word so that a shift moves both at once.
    skt_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (TABLE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_push) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_push) begin
            m_res_reg <= res_push_data;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_res_reg.payload, m_res_reg.key};
    assign m_axis_tuser  = m_res_reg.status;
    assign m_axis_tlast  = m_res_reg.last;

endmodule
`default_nettype wire

/* tb/sorted_key_table_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_test
// Self-checking testbench for the sorted key table. A scoreboard keeps its own
// sorted copy of the table and predicts every result of every accepted
// command. Stimulus runs in three parts. A directed opening covers the empty
// table, the extreme keys and every status but full. Random command mixes
// over a small pool of keys follow. Last, the table is filled to capacity,
// drained, and a short random mix ends the run. Both sides idle at random
// before that; once, the result side holds off till the command side stalls.
// ----------------------------------------------------------------------------
module sorted_key_table_test;
    import skt_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    // Longest legal gap without any transfer: the longest command, an insert
    // into a nearly full table, and the forced hold-off of HOLD_CYCLES both
    // fall well short of it, so this leaves a wide margin.
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int POOL_SIZE    = 16;

    // ------------------------------------------------------------------------
    // Scoreboard: a sorted shadow of the table and a queue of the results that
    // each accepted command is expected to cause, oldest first.
    // ------------------------------------------------------------------------
    class table_scoreboard;
        logic [KEY_W-1:0] key_tbl [TABLE_DEPTH];
        logic [PAY_W-1:0] pay_tbl [TABLE_DEPTH];
        int unsigned      fill;
        res_t             expected_q [$];
        int               errors;
        int               checked;
        int               status_seen [8];

        function new();
            fill    = 0;
            errors  = 0;
            checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void expect_result(status_t st, logic [KEY_W-1:0] k,
                                    logic [PAY_W-1:0] p, logic l);
            res_t r;
            r.status  = st;
            r.key     = k;
            r.payload = p;
            r.last    = l;
            expected_q.push_back(r);
        endfunction

        // Apply one accepted command to the shadow table.
        function void note_command(cmd_t cmd, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
            int unsigned pos;
            bit          hit;
            pos = 0;
            if (cmd == CMD_LIST) begin
                if (fill == 0) expect_result(ST_EMPTY, '0, '0, 1'b1);
                for (int i = 0; i < fill; i++)
                    expect_result(ST_LISTED, key_tbl[i], pay_tbl[i], i == fill - 1);
                return;
            end
            while (pos < fill && key_tbl[pos] < k) pos++;
            hit = (pos < fill) && (key_tbl[pos] == k);
            case (cmd)
                CMD_INSERT: begin
                    if (hit) begin
                        expect_result(ST_DUPLICATE, k, '0, 1'b1);
                    end else if (fill == TABLE_DEPTH) begin
                        expect_result(ST_FULL, k, '0, 1'b1);
                    end else begin
                        for (int i = fill; i > pos; i--) begin
                            key_tbl[i] = key_tbl[i-1];
                            pay_tbl[i] = pay_tbl[i-1];
                        end
                        key_tbl[pos] = k;
                        pay_tbl[pos] = p;
                        fill++;
                        expect_result(ST_INSERTED, k, '0, 1'b1);
                    end
                end
                CMD_LOOKUP: begin
                    if (hit) expect_result(ST_FOUND, k, pay_tbl[pos], 1'b1);
                    else     expect_result(ST_NOT_FOUND, k, '0, 1'b1);
                end
                default: begin
                    if (!hit) begin
                        expect_result(ST_NOT_FOUND, k, '0, 1'b1);
                    end else begin
                        expect_result(ST_REMOVED, k, pay_tbl[pos], 1'b1);
                        for (int i = pos; i + 1 < fill; i++) begin
                            key_tbl[i] = key_tbl[i+1];
                            pay_tbl[i] = pay_tbl[i+1];
                        end
                        fill--;
                    end
                end
            endcase
        endfunction

        function void check_result(res_t got);
            res_t want;
            bit   bad;
            checked++;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: unexpected result: status %0d key %h payload %h last %b",
                             $time, got.status, got.key, got.payload, got.last);
                return;
            end
            want = expected_q.pop_front();
            bad  = (got.status !== want.status) || (got.key !== want.key) ||
                   (got.payload !== want.payload) || (got.last !== want.last);
            if (bad) begin
                errors++;
                if (errors <= 40)
                    $display({"%0t: result %0d mismatch: expected status %0d key %h ",
                              "payload %h last %b, actual status %0d key %h payload %h last %b"},
                             $time, checked, want.status, want.key, want.payload, want.last,
                             got.status, got.key, got.payload, got.last);
            end else begin
                status_seen[want.status]++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the two stream channels.
    // ------------------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;    // entry_key [15:0], entry_payload [47:16]
    logic [1:0]  s_axis_tuser;    // command [1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;    // result_key [15:0], result_payload [47:16]
    logic [2:0]  m_axis_tuser;    // status [2:0]
    logic        m_axis_tlast;    // last

    always #CLK_HALF aclk = ~aclk;

    sorted_key_table dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    table_scoreboard  sb;
    int               tx_idle_pct;
    int               rx_idle_pct;
    int               rx_hold_cycles;
    int               commands_sent;
    int               idle_cycles;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    // ------------------------------------------------------------------------
    // Result side. The ready line changes on the falling edge. A pending
    // hold-off request takes priority over the random idling and is counted
    // down here, one cycle at a time.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (rx_hold_cycles > 0) begin
            m_axis_tready = 1'b0;
            rx_hold_cycles--;
        end else begin
            m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Every result transfer is checked at the rising edge where it happens.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result('{status_t'(m_axis_tuser), m_axis_tdata[15:0],
                              m_axis_tdata[47:16], m_axis_tlast});
    end

    // Watchdog: ends the run if no transfer happens on either side for too long.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog: no transfer for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, sb.expected_q.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command side. Called at a falling edge. The task may idle first, then
    // offers the command and waits for its transfer. It returns at the next
    // falling edge with tvalid still high, so that a following command goes
    // out back to back without valid dropping in between.
    // ------------------------------------------------------------------------
    task automatic send_cmd(cmd_t cmd, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {p, k};
        s_axis_tuser  = cmd;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_command(cmd, k, p);
        commands_sent++;
        @(negedge aclk);
    endtask

    // Mostly keys from a small pool, so that hits are common. The rest are
    // fully random and nearly always miss.
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(99) < 80) return key_pool[$urandom_range(POOL_SIZE - 1)];
        return KEY_W'($urandom);
    endfunction

    // The pool always keeps the two extreme keys.
    task automatic refresh_pool();
        foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
        key_pool[0] = '0;
        key_pool[1] = '1;
    endtask

    // A key already stored, if there is one, so that removes and lookups hit.
    function automatic logic [KEY_W-1:0] stored_or_pool_key();
        if (sb.fill > 0 && $urandom_range(99) < 60)
            return sb.key_tbl[$urandom_range(sb.fill - 1)];
        return pick_key();
    endfunction

    task automatic run_mix(int n);
        int sel;
        repeat (n) begin
            sel = $urandom_range(99);
            if (sel < 38)      send_cmd(CMD_INSERT, pick_key(), $urandom);
            else if (sel < 62) send_cmd(CMD_REMOVE, stored_or_pool_key(), $urandom);
            else if (sel < 92) send_cmd(CMD_LOOKUP, stored_or_pool_key(), $urandom);
            else               send_cmd(CMD_LIST, pick_key(), $urandom);
        end
    endtask

    // Fill the table to capacity, probe the refusals, list and look it up on a
    // full table, then drain it with removes, a few of which miss, and list it.
    task automatic fill_and_drain();
        while (sb.fill < TABLE_DEPTH) send_cmd(CMD_INSERT, KEY_W'($urandom), $urandom);
        repeat (3) send_cmd(CMD_INSERT, KEY_W'($urandom), $urandom);
        // A duplicate is reported even when the table is full.
        send_cmd(CMD_INSERT, sb.key_tbl[0], $urandom);
        send_cmd(CMD_INSERT, sb.key_tbl[TABLE_DEPTH-1], $urandom);
        send_cmd(CMD_LIST, '0, '0);
        repeat (2) send_cmd(CMD_LOOKUP, sb.key_tbl[$urandom_range(TABLE_DEPTH - 1)], $urandom);
        while (sb.fill > 0) begin
            if ($urandom_range(99) < 15) send_cmd(CMD_REMOVE, KEY_W'($urandom), $urandom);
            else send_cmd(CMD_REMOVE, sb.key_tbl[$urandom_range(sb.fill - 1)], $urandom);
        end
        send_cmd(CMD_LIST, '1, '1);
    endtask

    initial begin
        sb             = new();
        aresetn        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = CMD_INSERT;
        m_axis_tready  = 1'b0;
        tx_idle_pct    = 12;
        rx_idle_pct    = 64;
        rx_hold_cycles = 0;
        commands_sent  = 0;
        idle_cycles    = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed opening: empty table, extreme keys and payloads, and a
        // duplicate. Removes hit the middle, first and last positions, and
        // lists run on empty and non-empty tables.
        send_cmd(CMD_LIST,   '0,      '0);
        send_cmd(CMD_LOOKUP, '0,      '1);
        send_cmd(CMD_REMOVE, '1,      '0);
        send_cmd(CMD_INSERT, '0,      '0);
        send_cmd(CMD_INSERT, '1,      '1);
        send_cmd(CMD_INSERT, 16'h8000, 32'hA5A5_A5A5);
        send_cmd(CMD_INSERT, '0,      32'h1234_5678);
        send_cmd(CMD_LOOKUP, '1,      '0);
        send_cmd(CMD_LOOKUP, 16'h8000, '0);
        send_cmd(CMD_LOOKUP, 16'h7FFF, '1);
        send_cmd(CMD_LIST,   16'h5A5A, 32'h5A5A_5A5A);
        send_cmd(CMD_REMOVE, 16'h8000, '0);
        send_cmd(CMD_REMOVE, 16'h8000, '0);
        send_cmd(CMD_REMOVE, '0,      '0);
        send_cmd(CMD_LIST,   '0,      '0);
        send_cmd(CMD_REMOVE, '1,      '1);
        send_cmd(CMD_LIST,   '1,      '1);

        // First random part: the receiver stalls more often than the sender idles.
        refresh_pool();
        run_mix(100);

        // Second random part: roles swapped. Midway the receiver holds off for
        // a long stretch while commands keep coming, so that the block backs up
        // and stalls its command input.
        tx_idle_pct = 64;
        rx_idle_pct = 12;
        refresh_pool();
        run_mix(60);
        repeat (3) send_cmd(CMD_INSERT, KEY_W'($urandom), $urandom);
        rx_hold_cycles = HOLD_CYCLES;
        send_cmd(CMD_LIST, '0, '0);
        run_mix(5);

        // Third part: no idling on either side.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fill_and_drain();
        refresh_pool();
        run_mix(20);
        s_axis_tvalid = 1'b0;

        // Wait for every expected result, then a little longer to catch strays.
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d commands and checked %0d results, filling the table to %0d entries.",
                 commands_sent, sb.checked, TABLE_DEPTH);
        $display({"Statuses seen: inserted %0d, duplicate %0d, removed %0d, not found %0d, ",
                  "full %0d, found %0d, listed %0d, empty %0d."},
                 sb.status_seen[ST_INSERTED], sb.status_seen[ST_DUPLICATE],
                 sb.status_seen[ST_REMOVED], sb.status_seen[ST_NOT_FOUND],
                 sb.status_seen[ST_FULL], sb.status_seen[ST_FOUND],
                 sb.status_seen[ST_LISTED], sb.status_seen[ST_EMPTY]);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/skt_pkg.sv
rtl/core/skt_ram.sv
rtl/core/skt_engine.sv
rtl/core/sorted_key_table.sv
tb/sorted_key_table_test.sv
